// File: sv/geodetic_to_ecef_defines.svh
// assertion macros shared by the geodetic to ecef design
`ifndef GEODETIC_TO_ECEF_DEFINES_SVH
`define GEODETIC_TO_ECEF_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define GTE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, clocked on aclk, off while aresetn is low
`define GTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/gte_pkg.sv
// types and constants for the geodetic to ecef pipeline
`default_nettype none

package gte_pkg;

    localparam int LAT_W      = 32;
    localparam int LON_W      = 33;
    localparam int ALT_W      = 31;
    localparam int OUT_W      = 34;
    localparam int AXIS_W     = 33;
    localparam int ECC_W      = 37;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;
    localparam int TRIG_W     = 32;
    localparam int ROOT_W     = 31;
    localparam int N_W        = 34;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int DIV_STEPS    = 34;

    localparam int LAT_SINCOS = 3 + CORDIC_STEPS + 1;
    localparam int LAT_ROOT   = 4 + SQRT_STEPS;
    localparam int LAT_DIV    = DIV_STEPS + 2;
    localparam int LAT_RADIUS = LAT_ROOT + LAT_DIV;
    localparam int LAT_OUTPUT = 5;
    localparam int LAT_TOTAL  = LAT_SINCOS + LAT_RADIUS + LAT_OUTPUT;

    localparam logic [32:0] TURN_Q24    = 33'd6039797760;
    localparam logic [38:0] PHASE_RECIP = 39'd390937467654;
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [32:0] OUT_LIMIT   = 33'd8000000000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 34'sd8000000000;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -34'sd8000000000;

    localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0]  ECC_RESET  = 37'd7360548639;

    // arctangent of 2^-i as a fraction of one turn, 2^32 per turn
    localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
        30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    typedef enum logic [1:0] {
        QUAD_E = 2'd0,
        QUAD_N = 2'd1,
        QUAD_W = 2'd2,
        QUAD_S = 2'd3
    } quad_t;

    typedef enum logic [0:0] {
        CFG_AXIS = 1'b0,
        CFG_ECC  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [AXIS_W-1:0] axis_mm;
        logic [ECC_W-1:0]  ecc_q40;
    } earth_model_t;

endpackage

`default_nettype wire

// File: sv/gte_delay.sv
// shift-line delay with a shared advance enable
`default_nettype none

module gte_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: sv/gte_sincos.sv
// angle to phase conversion and pipelined cordic sine and cosine
`default_nettype none

module gte_sincos (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [gte_pkg::LON_W-1:0]   angle,
    output logic signed [gte_pkg::TRIG_W-1:0]  sin_q30,
    output logic signed [gte_pkg::TRIG_W-1:0]  cos_q30
);
    import gte_pkg::*;

    logic [33:0] red_wide;
    logic [32:0] red;
    logic [37:0] scaled;
    logic [56:0] prod_hi_reg, prod_hi_next;
    logic [57:0] prod_lo_reg, prod_lo_next;
    logic [76:0] quot_sum;
    logic [31:0] phase_reg;
    logic [32:0] phase_rnd;
    logic [33:0] z_wide;
    quad_t quad_reg;
    logic signed [TRIG_W-1:0] z0_reg;

    logic signed [TRIG_W-1:0] cx_reg [CORDIC_STEPS];
    logic signed [TRIG_W-1:0] cy_reg [CORDIC_STEPS];
    logic signed [TRIG_W-1:0] cz_reg [CORDIC_STEPS];
    quad_t cq_reg [CORDIC_STEPS];

    logic signed [TRIG_W-1:0] sin_reg, sin_next, cos_reg, cos_next;

    // reduce into one turn, then phase = round(r * 32 / 45) by reciprocal
    assign red_wide     = {angle[LON_W-1], angle} + {1'b0, TURN_Q24};
    assign red          = angle[LON_W-1] ? red_wide[32:0] : angle;
    assign scaled       = {red, 5'b00000} + 38'd22;
    assign prod_hi_next = 57'(scaled) * 57'(PHASE_RECIP[38:20]);
    assign prod_lo_next = 58'(scaled) * 58'(PHASE_RECIP[19:0]);
    assign quot_sum     = {prod_hi_reg, 20'b0} + 77'(prod_lo_reg);

    // nearest quadrant and residual angle
    assign phase_rnd = {1'b0, phase_reg} + 33'd536870912;
    assign z_wide    = {2'b00, phase_reg} - {1'b0, phase_rnd[32:30], 30'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            phase_reg   <= quot_sum[75:44];
            quad_reg    <= quad_t'(phase_rnd[31:30]);
            z0_reg      <= $signed(z_wide[31:0]);
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [TRIG_W-1:0] x_in, y_in, z_in, atan_k;
        quad_t q_in;

        if (k == 0) begin : g_first
            assign x_in = CORDIC_X0;
            assign y_in = '0;
            assign z_in = z0_reg;
            assign q_in = quad_reg;
        end else begin : g_next
            assign x_in = cx_reg[k-1];
            assign y_in = cy_reg[k-1];
            assign z_in = cz_reg[k-1];
            assign q_in = cq_reg[k-1];
        end

        assign atan_k = $signed({2'b00, ATAN_TURN[k]});

        always_ff @(posedge aclk) begin
            if (en) begin
                cq_reg[k] <= q_in;
                if (z_in >= 0) begin
                    cx_reg[k] <= x_in - (y_in >>> k);
                    cy_reg[k] <= y_in + (x_in >>> k);
                    cz_reg[k] <= z_in - atan_k;
                end else begin
                    cx_reg[k] <= x_in + (y_in >>> k);
                    cy_reg[k] <= y_in - (x_in >>> k);
                    cz_reg[k] <= z_in + atan_k;
                end
            end
        end
    end

    always_comb begin
        case (cq_reg[CORDIC_STEPS-1])
            QUAD_E: begin
                cos_next = cx_reg[CORDIC_STEPS-1];
                sin_next = cy_reg[CORDIC_STEPS-1];
            end
            QUAD_N: begin
                cos_next = -cy_reg[CORDIC_STEPS-1];
                sin_next = cx_reg[CORDIC_STEPS-1];
            end
            QUAD_W: begin
                cos_next = -cx_reg[CORDIC_STEPS-1];
                sin_next = -cy_reg[CORDIC_STEPS-1];
            end
            default: begin
                cos_next = cy_reg[CORDIC_STEPS-1];
                sin_next = -cx_reg[CORDIC_STEPS-1];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

// File: sv/gte_root.sv
// root of 1 - e2 sin^2, squaring stages and a one-bit-per-stage square root
`default_nettype none

module gte_root (
    input  logic                               aclk,
    input  logic                               en,
    input  gte_pkg::earth_model_t              model,
    input  logic signed [gte_pkg::TRIG_W-1:0]  sin_q30,
    output logic [gte_pkg::ROOT_W-1:0]         root
);
    import gte_pkg::*;

    logic signed [63:0] sq_full;
    logic [62:0] sq_reg;
    logic [62:0] s2_sum;
    logic [32:0] s2_full;
    logic [30:0] s2_reg;
    logic [49:0] pe_hi_reg;
    logic [48:0] pe_lo_reg;
    logic [67:0] t_sum;
    logic [30:0] w_reg;

    logic [60:0]       rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS];

    assign sq_full = 64'(sin_q30) * 64'(sin_q30);
    assign s2_sum  = sq_reg + 63'd536870912;
    assign s2_full = s2_sum[62:30];
    assign t_sum   = {pe_hi_reg, 18'b0} + 68'(pe_lo_reg) + (68'd1 << 39);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= sq_full[62:0];
            s2_reg    <= (s2_full > 33'(ONE_Q30)) ? ONE_Q30 : s2_full[30:0];
            pe_hi_reg <= 50'(s2_reg) * 50'(model.ecc_q40[36:18]);
            pe_lo_reg <= 49'(s2_reg) * 49'(model.ecc_q40[17:0]);
            w_reg     <= ONE_Q30 - {3'b000, t_sum[67:40]};
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
        localparam int BIT = SQRT_STEPS - 1 - k;
        logic [60:0]       rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [61:0]       trial;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = {w_reg, 30'b0};
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign trial = (62'(root_in) << (BIT + 1)) + (62'd1 << (2 * BIT));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? (rem_in - trial[60:0]) : rem_in;
                root_reg[k] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: sv/gte_div.sv
// restoring divide for the prime-vertical radius and its (1 - e2) scaling
`default_nettype none

module gte_div (
    input  logic                        aclk,
    input  logic                        en,
    input  gte_pkg::earth_model_t       model,
    input  logic [gte_pkg::ROOT_W-1:0]  root,
    output logic [gte_pkg::N_W-1:0]     n_mm,
    output logic [gte_pkg::N_W-1:0]     nz_mm
);
    import gte_pkg::*;

    logic [ROOT_W-1:0] drem_reg  [DIV_STEPS];
    logic [N_W-1:0]    dqb_reg   [DIV_STEPS];
    logic [ROOT_W-1:0] droot_reg [DIV_STEPS];

    logic [52:0]    pn_hi_reg;
    logic [51:0]    pn_lo_reg;
    logic [N_W-1:0] n1_reg;
    logic [71:0]    tn_sum;
    logic [N_W-1:0] n_reg, nz_reg;

    // numerator is axis * 2^30 + root / 2, the low bits shift in one per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_bit
        logic [ROOT_W-1:0] rem_in, root_in;
        logic [N_W-1:0]    qb_in;
        logic [31:0]       sh, diff;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = {2'b00, model.axis_mm[32:4]};
            assign qb_in   = {model.axis_mm[3:0], root[30:1]};
            assign root_in = root;
        end else begin : g_next
            assign rem_in  = drem_reg[k-1];
            assign qb_in   = dqb_reg[k-1];
            assign root_in = droot_reg[k-1];
        end

        assign sh   = {rem_in, qb_in[N_W-1]};
        assign take = sh >= {1'b0, root_in};
        assign diff = sh - {1'b0, root_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[k]  <= take ? diff[30:0] : sh[30:0];
                dqb_reg[k]   <= {qb_in[N_W-2:0], take};
                droot_reg[k] <= root_in;
            end
        end
    end

    assign tn_sum = {1'b0, pn_hi_reg, 18'b0} + 72'(pn_lo_reg) + (72'd1 << 39);

    always_ff @(posedge aclk) begin
        if (en) begin
            pn_hi_reg <= 53'(dqb_reg[DIV_STEPS-1]) * 53'(model.ecc_q40[36:18]);
            pn_lo_reg <= 52'(dqb_reg[DIV_STEPS-1]) * 52'(model.ecc_q40[17:0]);
            n1_reg    <= dqb_reg[DIV_STEPS-1];
            n_reg     <= n1_reg;
            nz_reg    <= n1_reg - {2'b00, tn_sum[71:40]};
        end
    end

    assign n_mm  = n_reg;
    assign nz_mm = nz_reg;

endmodule

`default_nettype wire

// File: sv/geodetic_to_ecef.sv
// top level: geodetic latitude, longitude and height to earth-centred x, y, z
`default_nettype none
`include "geodetic_to_ecef_defines.svh"

// Converts one geodetic point per transaction into earth-centred cartesian
// coordinates for the ellipsoid held in the two configuration registers
// (semi-major axis in mm, first eccentricity squared in Q0.40, both reset
// to WGS84). Fully pipelined: one point is accepted every cycle while the
// result side does not stall. The pipeline runs through the phase and
// 30-step cordic pipeline, the squaring and 31-step square root, the
// 34-step radius divider with its (1 - e2) scaling and the five output
// product and saturation stages. The whole pipeline moves on one advance
// enable, so a stall on the result side freezes it without losing or
// repeating a point. Results saturate at +/-8000000000 mm. Write the
// configuration only while no transaction is in flight.
module geodetic_to_ecef (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gte_pkg::IN_DATA_W-1:0]       s_tdata,   // lat_deg, lon_deg, alt_mm
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gte_pkg::OUT_DATA_W-1:0]      m_tdata,   // ecef_x, ecef_y, ecef_z, zero pad
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  gte_pkg::cfg_index_t                 cfg_index,
    input  logic [gte_pkg::ECC_W-1:0]           cfg_data
);
    import gte_pkg::*;

    // whole pipeline advances when the output register is free or drained
    logic adv;
    logic [LAT_TOTAL-1:0] valid_reg;

    // earth model registers
    logic [AXIS_W-1:0] axis_reg;
    logic [ECC_W-1:0]  ecc_reg;
    earth_model_t      model;

    // unpacked input fields
    logic signed [LAT_W-1:0] lat_deg;
    logic signed [LON_W-1:0] lon_deg;
    logic signed [ALT_W-1:0] alt_mm;

    // trig results and their delayed copies
    logic signed [TRIG_W-1:0] sin_lat, cos_lat, sin_lon, cos_lon;
    logic [4*TRIG_W-1:0]      trig_d;
    logic signed [TRIG_W-1:0] cl_d, sl_d, co_d, so_d;
    logic [ALT_W-1:0]         alt_d_bits;
    logic signed [ALT_W-1:0]  alt_d;

    // radius path
    logic [ROOT_W-1:0] root;
    logic [N_W-1:0]    n_mm, nz_mm;

    // output stages
    logic signed [35:0] rad_sum, radz_sum, rad_neg, radz_neg;
    logic [34:0] rad_mag_reg, radz_mag_reg;
    logic        rad_sgn_reg, radz_sgn_reg;
    logic [31:0] cl_mag_reg, sl_mag_reg, co_mag_reg, so_mag_reg;
    logic        cl_sgn_reg, sl_sgn_reg, co_sgn_reg, so_sgn_reg;

    logic [66:0] pxy_reg, pz_reg;
    logic        sxy_reg, sz_reg;
    logic [31:0] co2_mag_reg, so2_mag_reg;
    logic        co2_sgn_reg, so2_sgn_reg;

    logic [66:0] pxy_rnd, pz_rnd;
    logic [36:0] m1_reg, mz_reg;
    logic        s1_reg, sz1_reg;
    logic [31:0] co3_mag_reg, so3_mag_reg;
    logic        co3_sgn_reg, so3_sgn_reg;

    logic [68:0] px_reg, py_reg;
    logic        sx_reg, sy_reg;
    logic [36:0] mz2_reg;
    logic        sz2_reg;

    logic [68:0] px_rnd, py_rnd;
    logic [OUT_W-1:0] x_reg, y_reg, z_reg;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // clamp a magnitude to the output range and put the sign back
    function automatic logic [OUT_W-1:0] sat_apply(input logic [38:0] mag, input logic neg);
        logic [32:0]      lim;
        logic [OUT_W-1:0] ext;
        lim = (mag > 39'(OUT_LIMIT)) ? OUT_LIMIT : mag[32:0];
        ext = {1'b0, lim};
        return neg ? (~ext + 34'd1) : ext;
    endfunction

    // handshakes
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign m_tvalid  = valid_reg[LAT_TOTAL-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAT_TOTAL-2:0], s_tvalid};
        end
    end

    // configuration transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= AXIS_RESET;
            ecc_reg  <= ECC_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AXIS: axis_reg <= cfg_data[AXIS_W-1:0];
                CFG_ECC:  ecc_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign model.axis_mm = axis_reg;
    assign model.ecc_q40 = ecc_reg;

    // input fields, lowest first
    assign lat_deg = s_tdata[LAT_W-1:0];
    assign lon_deg = s_tdata[LAT_W+LON_W-1:LAT_W];
    assign alt_mm  = s_tdata[LAT_W+LON_W+ALT_W-1:LAT_W+LON_W];

    // sine and cosine of both angles
    gte_sincos u_lat_trig (
        .aclk    (aclk),
        .en      (adv),
        .angle   ({lat_deg[LAT_W-1], lat_deg}),
        .sin_q30 (sin_lat),
        .cos_q30 (cos_lat)
    );

    gte_sincos u_lon_trig (
        .aclk    (aclk),
        .en      (adv),
        .angle   (lon_deg),
        .sin_q30 (sin_lon),
        .cos_q30 (cos_lon)
    );

    // prime-vertical radius from the latitude sine
    gte_root u_root (
        .aclk    (aclk),
        .en      (adv),
        .model   (model),
        .sin_q30 (sin_lat),
        .root    (root)
    );

    gte_div u_div (
        .aclk  (aclk),
        .en    (adv),
        .model (model),
        .root  (root),
        .n_mm  (n_mm),
        .nz_mm (nz_mm)
    );

    // trig values wait for the radius, height waits for the whole front end
    gte_delay #(
        .WIDTH (4 * TRIG_W),
        .DEPTH (LAT_RADIUS)
    ) u_trig_dly (
        .aclk (aclk),
        .en   (adv),
        .din  ({cos_lat, sin_lat, cos_lon, sin_lon}),
        .dout (trig_d)
    );

    gte_delay #(
        .WIDTH (ALT_W),
        .DEPTH (LAT_SINCOS + LAT_RADIUS)
    ) u_alt_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (alt_mm),
        .dout (alt_d_bits)
    );

    assign cl_d  = trig_d[4*TRIG_W-1:3*TRIG_W];
    assign sl_d  = trig_d[3*TRIG_W-1:2*TRIG_W];
    assign co_d  = trig_d[2*TRIG_W-1:TRIG_W];
    assign so_d  = trig_d[TRIG_W-1:0];
    assign alt_d = alt_d_bits;

    // stage 1: add height, split everything into sign and magnitude
    assign rad_sum  = $signed({2'b00, n_mm}) + 36'(alt_d);
    assign radz_sum = $signed({2'b00, nz_mm}) + 36'(alt_d);
    assign rad_neg  = -rad_sum;
    assign radz_neg = -radz_sum;

    // stage 3 and 5 rounding, half away from zero on magnitudes
    assign pxy_rnd = pxy_reg + (67'd1 << 29);
    assign pz_rnd  = pz_reg + (67'd1 << 29);
    assign px_rnd  = px_reg + (69'd1 << 29);
    assign py_rnd  = py_reg + (69'd1 << 29);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            rad_mag_reg  <= rad_sum[35] ? rad_neg[34:0] : rad_sum[34:0];
            rad_sgn_reg  <= rad_sum[35];
            radz_mag_reg <= radz_sum[35] ? radz_neg[34:0] : radz_sum[34:0];
            radz_sgn_reg <= radz_sum[35];
            cl_mag_reg   <= mag32(cl_d);
            cl_sgn_reg   <= cl_d[TRIG_W-1];
            sl_mag_reg   <= mag32(sl_d);
            sl_sgn_reg   <= sl_d[TRIG_W-1];
            co_mag_reg   <= mag32(co_d);
            co_sgn_reg   <= co_d[TRIG_W-1];
            so_mag_reg   <= mag32(so_d);
            so_sgn_reg   <= so_d[TRIG_W-1];
            // stage 2: radius times cos(lat), z radius times sin(lat)
            pxy_reg      <= 67'(rad_mag_reg) * 67'(cl_mag_reg);
            pz_reg       <= 67'(radz_mag_reg) * 67'(sl_mag_reg);
            sxy_reg      <= rad_sgn_reg ^ cl_sgn_reg;
            sz_reg       <= radz_sgn_reg ^ sl_sgn_reg;
            co2_mag_reg  <= co_mag_reg;
            co2_sgn_reg  <= co_sgn_reg;
            so2_mag_reg  <= so_mag_reg;
            so2_sgn_reg  <= so_sgn_reg;
            // stage 3: round back to mm
            m1_reg       <= pxy_rnd[66:30];
            mz_reg       <= pz_rnd[66:30];
            s1_reg       <= sxy_reg;
            sz1_reg      <= sz_reg;
            co3_mag_reg  <= co2_mag_reg;
            co3_sgn_reg  <= co2_sgn_reg;
            so3_mag_reg  <= so2_mag_reg;
            so3_sgn_reg  <= so2_sgn_reg;
            // stage 4: times cos(lon) and sin(lon)
            px_reg       <= 69'(m1_reg) * 69'(co3_mag_reg);
            py_reg       <= 69'(m1_reg) * 69'(so3_mag_reg);
            sx_reg       <= s1_reg ^ co3_sgn_reg;
            sy_reg       <= s1_reg ^ so3_sgn_reg;
            mz2_reg      <= mz_reg;
            sz2_reg      <= sz1_reg;
            // stage 5: round, saturate, output register
            x_reg        <= sat_apply(px_rnd[68:30], sx_reg);
            y_reg        <= sat_apply(py_rnd[68:30], sy_reg);
            z_reg        <= sat_apply(39'(mz2_reg), sz2_reg);
        end
    end

    assign m_tdata = {2'b00, z_reg, y_reg, x_reg};

    // saturation keeps the delivered x and z coordinates inside the range
    `GTE_ASSERT_IMPL(a_x_range, m_tvalid, ($signed(x_reg) <= OUT_MAX) && ($signed(x_reg) >= OUT_MIN))
    `GTE_ASSERT_IMPL(a_z_range, m_tvalid, ($signed(z_reg) <= OUT_MAX) && ($signed(z_reg) >= OUT_MIN))
    // a stall freezes the whole pipeline and the held result
    `GTE_ASSERT_NEXT(a_stall_hold, !adv, $stable(valid_reg) && $stable(x_reg) && $stable(z_reg))
    // an accepted transaction enters the first stage
    `GTE_ASSERT_NEXT(a_enter, s_tvalid && s_tready, valid_reg[0])
    // a taken result is not shown again unless a new one followed it
    `GTE_ASSERT_NEXT(a_no_repeat, m_tvalid && m_tready && !valid_reg[LAT_TOTAL-2], !m_tvalid)

endmodule

`default_nettype wire
